// ----- src/piecewise_linear_interpolator_assert.svh -----
// Assertion macros for the piecewise linear interpolator.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PLI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pli: assertion failed");
// next-cycle implication
`define PLI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pli: assertion failed");
`else
`define PLI_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PLI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/pli_pkg.sv -----
// Package for the piecewise linear interpolator: widths, codes and types.
// No dependencies.
package pli_pkg;

   localparam int unsigned MAX_POINTS_DEF = 16;
   localparam int unsigned VAL_W          = 16;
   localparam int unsigned IDX_W          = 4;
   localparam int unsigned PTS_W          = 5;
   localparam int unsigned STAT_W         = 3;
   localparam int unsigned REQ_DATA_W     = 56;
   localparam int unsigned RSP_DATA_W     = 16;
   localparam int unsigned PROD_W         = 34;
   localparam int unsigned DIV_CNT_W      = 6;
   localparam int unsigned WIDE_IDX_W     = 9;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [PTS_W-1:0] PTS_RESET = 5'd2;

   typedef enum logic [STAT_W-1:0] {
      ST_INSIDE = 3'd0,
      ST_BELOW  = 3'd1,
      ST_ABOVE  = 3'd2,
      ST_NONE   = 3'd3,
      ST_FLAT   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_DECIDE,
      S_MUL,
      S_PREP,
      S_DIV,
      S_SUM,
      S_FINISH
   } state_type;

   // one calibration point, pressure in the low half
   typedef struct packed {
      logic signed [VAL_W-1:0] hgt;
      logic signed [VAL_W-1:0] pres;
   } point_type;

endpackage

// ----- src/piecewise_linear_interpolator.sv -----
// Piecewise linear interpolator: calibration table, segment walk, multiply and
// restoring divider under one sequencer. Depends on pli_pkg and the assert header.
//
// Usage:
//  - req channel: tuser is the command (write entry / evaluate). A write word
//    stores one table point and yields no response word.
//  - An evaluate word walks the table one entry per cycle through the single
//    read port over the points in use (clamped to 2..MAX_POINTS), then picks the
//    inside, first or last segment, multiplies once and runs a 34-step
//    restoring divider, one quotient bit per cycle.
//  - A zero-width segment, or a query to which no segment applies, skips the
//    multiply and the divider.
//  - req_tready is high only while idle; one word is in work at a time.
//  - The rsp word sits in an output register; a new word can be accepted while
//    it waits. If the receiver still stalls when the next result is done, the
//    sequencer holds that result until the register frees up.
//  - csr port sets the number of points in use; always ready, write it only
//    while the block is idle.
//  - Reset: synchronous, active high. Clears the sequencer and the response
//    valid, sets points in use to 2. Table contents are undefined until written.
`include "piecewise_linear_interpolator_assert.svh"

module piecewise_linear_interpolator
   import pli_pkg::*;
#(
   parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: entry_index[3:0], entry_pressure[19:4], entry_height[35:20],
   //        query_pressure[51:36], zero pad [55:52]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[0]
   input  logic                  req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: height[15:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[2:0]
   output logic [STAT_W-1:0]     rsp_tuser,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [PTS_W-1:0]      csr_data
);

   localparam int unsigned IW = $clog2(MAX_POINTS);
   localparam int unsigned CW = $clog2(MAX_POINTS + 1);

   // request fields
   logic [IDX_W-1:0]        req_idx;
   logic signed [VAL_W-1:0] req_entry_p;
   logic signed [VAL_W-1:0] req_entry_h;
   logic signed [VAL_W-1:0] req_query;

   assign req_idx     = req_tdata[3:0];
   assign req_entry_p = req_tdata[19:4];
   assign req_entry_h = req_tdata[35:20];
   assign req_query   = req_tdata[51:36];

   // control registers
   state_type             state_ff, state_in;
   logic [PTS_W-1:0]      pts_ff, pts_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic signed [VAL_W-1:0] q_ff, q_in;
   point_type               prev_ff, prev_in;
   point_type               first0_ff, first0_in, first1_ff, first1_in;
   point_type               last0_ff, last0_in, last1_ff, last1_in;
   point_type               seg0_ff, seg0_in, seg1_ff, seg1_in;
   logic                    found_ff, found_in;
   logic signed [VAL_W:0]   dq_ff, dq_in, dy_ff, dy_in, dx_ff, dx_in;
   logic signed [VAL_W-1:0] base_ff, base_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0]       dvd_ff, dvd_in;
   logic [VAL_W:0]          dvs_ff, dvs_in;
   logic [VAL_W:0]          rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic signed [VAL_W-1:0] res_h_ff, res_h_in;
   status_type              res_st_ff, res_st_in;
   logic [VAL_W-1:0]        rsp_height_ff, rsp_height_in;
   status_type              rsp_status_ff, rsp_status_in;

   // table memory
   point_type               tbl_mem_ff [MAX_POINTS];
   point_type               rd_ff;
   logic                    mem_we;
   logic [IW-1:0]           mem_waddr;
   logic                    rd_en;
   logic [IW-1:0]           rd_addr;

   // points in use, clamped to 2..MAX_POINTS
   logic [WIDE_IDX_W-1:0]   pts_wide;
   logic [WIDE_IDX_W-1:0]   n_wide;
   logic [CW-1:0]           n_used;
   logic [WIDE_IDX_W-1:0]   widx_wide;

   assign pts_wide  = WIDE_IDX_W'(pts_ff);
   assign widx_wide = WIDE_IDX_W'(req_idx);

   always_comb begin
      priority if (pts_wide < WIDE_IDX_W'(2)) begin
         n_wide = WIDE_IDX_W'(2);
      end else if (pts_wide > WIDE_IDX_W'(MAX_POINTS)) begin
         n_wide = WIDE_IDX_W'(MAX_POINTS);
      end else begin
         n_wide = pts_wide;
      end
   end

   assign n_used = n_wide[CW-1:0];

   // port drives
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_height_ff;
   assign rsp_tuser  = rsp_status_ff;

   // sequencer: next state and datapath next values
   always_comb begin
      point_type               a0;
      point_type               a1;
      status_type              st;
      logic signed [VAL_W-1:0] refx;
      logic signed [VAL_W-1:0] base;
      logic [VAL_W+1:0]        rem_sh;
      logic [VAL_W+1:0]        rem_diff;
      logic                    qbit;
      logic signed [PROD_W:0]  quo_s;
      logic signed [PROD_W+1:0] sum;

      a0       = first0_ff;
      a1       = first1_ff;
      st       = ST_NONE;
      refx     = '0;
      base     = '0;
      rem_sh   = '0;
      rem_diff = '0;
      qbit     = 1'b0;
      quo_s    = '0;
      sum      = '0;

      state_in      = state_ff;
      pts_in        = pts_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cnt_in        = cnt_ff;
      q_in          = q_ff;
      prev_in       = prev_ff;
      first0_in     = first0_ff;
      first1_in     = first1_ff;
      last0_in      = last0_ff;
      last1_in      = last1_ff;
      seg0_in       = seg0_ff;
      seg1_in       = seg1_ff;
      found_in      = found_ff;
      dq_in         = dq_ff;
      dy_in         = dy_ff;
      dx_in         = dx_ff;
      base_in       = base_ff;
      prod_in       = prod_ff;
      dvd_in        = dvd_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      div_cnt_in    = div_cnt_ff;
      res_h_in      = res_h_ff;
      res_st_in     = res_st_ff;
      rsp_height_in = rsp_height_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = widx_wide[IW-1:0];
      rd_en         = 1'b0;
      rd_addr       = cnt_ff[IW-1:0];

      // register write
      if (csr_valid && csr_ready) begin
         pts_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_WRITE) begin
                  mem_we = (widx_wide < WIDE_IDX_W'(MAX_POINTS));
               end else begin
                  q_in     = req_query;
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = S_WALK;
               end
            end
         end

         // one table entry per cycle; the read data is registered and trails the address
         S_WALK: begin
            rd_en  = (cnt_ff < n_used);
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff != '0) begin
               if (cnt_ff == CW'(1)) begin
                  first0_in = rd_ff;
               end
               if (cnt_ff == CW'(2)) begin
                  first1_in = rd_ff;
               end
               if ((cnt_ff >= CW'(2)) && !found_ff &&
                   (q_ff >= prev_ff.pres) && (q_ff <= rd_ff.pres)) begin
                  found_in = 1'b1;
                  seg0_in  = prev_ff;
                  seg1_in  = rd_ff;
               end
               prev_in = rd_ff;
               if (cnt_ff == n_used) begin
                  last0_in = prev_ff;
                  last1_in = rd_ff;
                  state_in = S_DECIDE;
               end
            end
         end

         // pick the segment, handle flat and empty cases
         S_DECIDE: begin
            priority if (found_ff) begin
               a0 = seg0_ff;
               a1 = seg1_ff;
               st = ST_INSIDE;
            end else if (q_ff < first0_ff.pres) begin
               a0 = first0_ff;
               a1 = first1_ff;
               st = ST_BELOW;
            end else if (q_ff > last1_ff.pres) begin
               a0 = last0_ff;
               a1 = last1_ff;
               st = ST_ABOVE;
            end else begin
               st = ST_NONE;
            end
            if (st == ST_ABOVE) begin
               base = a1.hgt;
               refx = a1.pres;
            end else begin
               base = a0.hgt;
               refx = a0.pres;
            end
            priority if (st == ST_NONE) begin
               res_h_in  = '0;
               res_st_in = ST_NONE;
               state_in  = S_FINISH;
            end else if (a0.pres == a1.pres) begin
               res_h_in  = base;
               res_st_in = ST_FLAT;
               state_in  = S_FINISH;
            end else begin
               dq_in     = {q_ff[VAL_W-1], q_ff} - {refx[VAL_W-1], refx};
               dy_in     = {a1.hgt[VAL_W-1], a1.hgt} - {a0.hgt[VAL_W-1], a0.hgt};
               dx_in     = {a1.pres[VAL_W-1], a1.pres} - {a0.pres[VAL_W-1], a0.pres};
               base_in   = base;
               res_st_in = st;
               state_in  = S_MUL;
            end
         end

         S_MUL: begin
            prod_in  = dq_ff * dy_ff;
            state_in = S_PREP;
         end

         // magnitudes and quotient sign for the divider
         S_PREP: begin
            dvd_in     = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
            dvs_in     = dx_ff[VAL_W] ? (VAL_W+1)'(-dx_ff) : (VAL_W+1)'(dx_ff);
            neg_in     = prod_ff[PROD_W-1] ^ dx_ff[VAL_W];
            rem_in     = '0;
            div_cnt_in = DIV_CNT_W'(PROD_W - 1);
            state_in   = S_DIV;
         end

         // restoring divide, one quotient bit per cycle
         S_DIV: begin
            rem_sh = {rem_ff, dvd_ff[PROD_W-1]};
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_diff = rem_sh - {1'b0, dvs_ff};
               rem_in   = rem_diff[VAL_W:0];
               qbit     = 1'b1;
            end else begin
               rem_in = rem_sh[VAL_W:0];
            end
            dvd_in     = {dvd_ff[PROD_W-2:0], qbit};
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = S_SUM;
            end
         end

         // signed quotient plus base, saturated
         S_SUM: begin
            quo_s = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
            sum   = (PROD_W+2)'(base_ff) + (PROD_W+2)'(quo_s);
            priority if (sum > (PROD_W+2)'(32767)) begin
               res_h_in = 16'sh7FFF;
            end else if (sum < -(PROD_W+2)'(32768)) begin
               res_h_in = 16'sh8000;
            end else begin
               res_h_in = sum[VAL_W-1:0];
            end
            state_in = S_FINISH;
         end

         // wait for the output register to free up
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = res_h_ff;
               rsp_status_in = res_st_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pts_ff       <= PTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pts_ff       <= pts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      q_ff          <= q_in;
      prev_ff       <= prev_in;
      first0_ff     <= first0_in;
      first1_ff     <= first1_in;
      last0_ff      <= last0_in;
      last1_ff      <= last1_in;
      seg0_ff       <= seg0_in;
      seg1_ff       <= seg1_in;
      found_ff      <= found_in;
      dq_ff         <= dq_in;
      dy_ff         <= dy_in;
      dx_ff         <= dx_in;
      base_ff       <= base_in;
      prod_ff       <= prod_in;
      dvd_ff        <= dvd_in;
      dvs_ff        <= dvs_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      div_cnt_ff    <= div_cnt_in;
      res_h_ff      <= res_h_in;
      res_st_ff     <= res_st_in;
      rsp_height_ff <= rsp_height_in;
      rsp_status_ff <= rsp_status_in;
   end

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem_ff[mem_waddr] <= '{hgt: req_entry_h, pres: req_entry_p};
      end
      if (rd_en) begin
         rd_ff <= tbl_mem_ff[rd_addr];
      end
   end

   // checks
   `PLI_ASSERT_NEXT(a_eval_starts_walk, clock, reset, req_tvalid && req_tready && (req_tuser == CMD_EVAL), (state_ff == S_WALK) && (cnt_ff == '0))
   `PLI_ASSERT_SAME(a_walk_bound, clock, reset, state_ff == S_WALK, cnt_ff <= n_used)
   `PLI_ASSERT_SAME(a_rem_below_divisor, clock, reset, state_ff == S_DIV, (rem_ff < dvs_ff) && (dvs_ff != '0))
   `PLI_ASSERT_NEXT(a_div_ends, clock, reset, (state_ff == S_DIV) && (div_cnt_ff == '0), state_ff == S_SUM)
   `PLI_ASSERT_SAME(a_none_is_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_NONE), rsp_height_ff == '0)

endmodule
